FILE: sv/lwr_pkg.sv
// Shared constants, types and coefficient tables for the Lambert W rational approximation.
// Used by every module of the block; depends on nothing else.
package lwr_pkg;

  // Number formats
  localparam int FRAC_BITS = 30;             // fraction bits of the sample and the result
  localparam int IFB       = 57;             // fraction bits of the internal format
  localparam int XW        = 28;             // width of the sample and result fields
  localparam int XMAG_W    = XW - 1;         // magnitude of a clamped sample
  localparam int FW        = 64;             // internal signed word
  localparam int MAG_W     = FW - 1;         // magnitude of an internal word

  // Split multiplier widths (low half 32 bits, high half the rest)
  localparam int LO_W      = 32;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int PL_W      = LO_W + XMAG_W;
  localparam int PH_W      = HI_W + XMAG_W;
  localparam int SUM_W     = MAG_W + XMAG_W + 1;
  localparam int HMAG_W    = SUM_W - FRAC_BITS;  // Horner product magnitude
  localparam int FMAG_W    = SUM_W - IFB;        // final product magnitude

  // Divider
  localparam int LOWB_W    = 5;              // quotient below 32: five integer bits
  localparam int DIV_STEPS = MAG_W;          // one quotient bit per stage

  // Input clamp: -round(2^FRAC_BITS / 10)
  localparam longint unsigned X_MIN_RAW = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [XMAG_W-1:0] X_MIN_MAG = XMAG_W'(X_MIN_RAW);
  localparam logic signed [XW-1:0] X_LOW = XW'(-longint'(X_MIN_RAW));

  // Output floor
  localparam logic [XW-1:0] W_MIN_MAG = XW'(121000000);
  localparam logic signed [XW-1:0] W_MIN = XW'(-longint'(121000000));

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

  typedef logic signed [FW-1:0] fx_t;

  // Control that rides along with the divider
  typedef struct packed {
    logic [XMAG_W-1:0] xm;     // sample magnitude
    logic              pneg;   // numerator sign
    logic              sat;    // quotient at or above 32, or zero divisor
    logic              big;    // divisor above 2^62
  } div_ctl_t;

  // Decimal coefficient to Q57: ip + round(fp / 1e18), half up
  function automatic fx_t coef_q57(input logic neg, input logic [63:0] ip,
                                   input logic [63:0] fp);
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] m;
    int i;
    r = fp;
    t = '0;
    for (i = 0; i < IFB + 1; i++) begin
      r = r << 1;
      t = t << 1;
      if (r >= DEC_ONE) begin
        r    = r - DEC_ONE;
        t[0] = 1'b1;
      end
    end
    m = (ip << IFB) + ((t + 64'd1) >> 1);
    return neg ? fx_t'(-m) : fx_t'(m);
  endfunction

  localparam fx_t COEF_P [6] = '{
    coef_q57(1'b1, 64'd0,  64'd86339950561501433),
    coef_q57(1'b1, 64'd1,  64'd643038718148164640),
    coef_q57(1'b1, 64'd7,  64'd712479139182737380),
    coef_q57(1'b1, 64'd14, 64'd101449554538245400),
    coef_q57(1'b1, 64'd10, 64'd226907994925761600),
    coef_q57(1'b1, 64'd2,  64'd172360028363066910)
  };

  localparam fx_t COEF_Q [6] = '{
    coef_q57(1'b0, 64'd1,  64'd0),
    coef_q57(1'b0, 64'd7,  64'd447754069457392430),
    coef_q57(1'b0, 64'd20, 64'd439264308726654100),
    coef_q57(1'b0, 64'd25, 64'd100196107777419300),
    coef_q57(1'b0, 64'd13, 64'd125608084902331900),
    coef_q57(1'b0, 64'd2,  64'd116403248436015880)
  };

  localparam fx_t COEF_A0 = coef_q57(1'b0, 64'd1, 64'd86339950561523440);

endpackage

FILE: sv/lambert_w_rational_approx.sv
// Top level of the Lambert W rational approximation on [-0.1, 0], Q30 in and out.
// Instantiates lwr_horner_step, lwr_div_stage and lwr_final; depends on lwr_pkg.
//
//   channel   ports                           direction
//   input     in_valid, in_ready, in_x_in     x sample, signed Q30, 28 bits
//   result    out_valid, out_ready, out_w_out W(x), signed Q30, 28 bits, saturated
//
// One transaction per cycle sustained unless an output stall holds the pipeline; stages in order:
// input clamp, Horner, divider setup, divider (one bit per stage), final scaling, output register.
// The 63-stage restoring divider sets the latency.
// Synchronous active-low reset clears the valid bits only.
// A stall at the output freezes the whole pipeline only when the last stage holds
// a transaction; bubbles keep moving so new samples are taken while a result waits.
module lambert_w_rational_approx (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [27:0]         in_x_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [27:0]         out_w_out
);

  localparam int NSTEP = 5;
  localparam int ND    = lwr_pkg::DIV_STEPS;

  logic                        en, out_en;
  logic                        x_vld_r;
  logic [lwr_pkg::XMAG_W-1:0]  xm_nxt, xm_r;
  logic signed [lwr_pkg::XW-1:0] xneg;

  logic                        hvld [NSTEP+1];
  logic [lwr_pkg::XMAG_W-1:0]  hx   [NSTEP+1];
  lwr_pkg::fx_t                hv   [NSTEP+1][2];

  lwr_pkg::fx_t                pabs;
  logic [lwr_pkg::MAG_W-1:0]   n_nxt, d_nxt;
  lwr_pkg::div_ctl_t           ctl_nxt;

  logic                        dvld [ND+1];
  logic [lwr_pkg::MAG_W-1:0]   drem [ND+1];
  logic [lwr_pkg::MAG_W-1:0]   dquo [ND+1];
  logic [lwr_pkg::LOWB_W-1:0]  dlow [ND+1];
  logic [lwr_pkg::MAG_W-1:0]   dd   [ND+1];
  lwr_pkg::div_ctl_t           dctl [ND+1];

  logic                        fin_vld, fin_neg;
  logic [lwr_pkg::FMAG_W-1:0]  fin_res;
  logic signed [lwr_pkg::XW-1:0] w_nxt;
  logic                        out_valid_r;
  logic signed [lwr_pkg::XW-1:0] out_w_r;

  // Pipeline advance: hold only when a finished transaction cannot leave
  assign out_en   = !out_valid_r || out_ready;
  assign en       = out_en || !fin_vld;
  assign in_ready = en;

  // Clamp sample to [-0.1, 0] and keep its magnitude
  always_comb begin
    xneg = -in_x_in;
    if (!in_x_in[lwr_pkg::XW-1]) begin
      xm_nxt = '0;
    end else if (in_x_in < lwr_pkg::X_LOW) begin
      xm_nxt = lwr_pkg::X_MIN_MAG;
    end else begin
      xm_nxt = xneg[lwr_pkg::XMAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else if (en) begin
      x_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r <= xm_nxt;
    end
  end

  // Horner chain for P (lane 0) and Q (lane 1)
  assign hvld[0]  = x_vld_r;
  assign hx[0]    = xm_r;
  assign hv[0][0] = lwr_pkg::COEF_P[5];
  assign hv[0][1] = lwr_pkg::COEF_Q[5];

  for (genvar k = 0; k < NSTEP; k++) begin : g_horner
    lwr_pkg::fx_t cf [2];
    assign cf[0] = lwr_pkg::COEF_P[NSTEP-1-k];
    assign cf[1] = lwr_pkg::COEF_Q[NSTEP-1-k];
    lwr_horner_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (hvld[k]),
      .xm_i   (hx[k]),
      .v_i    (hv[k]),
      .coef_i (cf),
      .vld_o  (hvld[k+1]),
      .xm_o   (hx[k+1]),
      .v_o    (hv[k+1])
    );
  end

  // Divider setup: magnitudes, range flags
  always_comb begin
    pabs  = -hv[NSTEP][0];
    n_nxt = hv[NSTEP][0][lwr_pkg::FW-1] ? pabs[lwr_pkg::MAG_W-1:0]
                                        : hv[NSTEP][0][lwr_pkg::MAG_W-1:0];
    d_nxt = (!hv[NSTEP][1][lwr_pkg::FW-1] && hv[NSTEP][1] != '0)
            ? hv[NSTEP][1][lwr_pkg::MAG_W-1:0] : '0;
    ctl_nxt.xm   = hx[NSTEP];
    ctl_nxt.pneg = hv[NSTEP][0][lwr_pkg::FW-1];
    ctl_nxt.sat  = (d_nxt == '0) ||
                   ({{lwr_pkg::LOWB_W{1'b0}}, n_nxt} >= {d_nxt, {lwr_pkg::LOWB_W{1'b0}}});
    ctl_nxt.big  = d_nxt[lwr_pkg::MAG_W-1] && (d_nxt[lwr_pkg::MAG_W-2:0] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= hvld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= {{lwr_pkg::LOWB_W{1'b0}}, n_nxt[lwr_pkg::MAG_W-1:lwr_pkg::LOWB_W]};
      dlow[0] <= n_nxt[lwr_pkg::LOWB_W-1:0];
      dquo[0] <= '0;
      dd[0]   <= d_nxt;
      dctl[0] <= ctl_nxt;
    end
  end

  // Divider chain, one quotient bit per stage
  for (genvar i = 0; i < ND; i++) begin : g_div
    lwr_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dvld[i]),
      .rem_i (drem[i]),
      .quo_i (dquo[i]),
      .low_i (dlow[i]),
      .d_i   (dd[i]),
      .ctl_i (dctl[i]),
      .vld_o (dvld[i+1]),
      .rem_o (drem[i+1]),
      .quo_o (dquo[i+1]),
      .low_o (dlow[i+1]),
      .d_o   (dd[i+1]),
      .ctl_o (dctl[i+1])
    );
  end

  lwr_final u_final (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (dvld[ND]),
    .quo_i (dquo[ND]),
    .ctl_i (dctl[ND]),
    .vld_o (fin_vld),
    .res_o (fin_res),
    .neg_o (fin_neg)
  );

  // Sign and saturate to [W_MIN, 0]
  always_comb begin
    if (!fin_neg) begin
      w_nxt = '0;
    end else if (fin_res > lwr_pkg::FMAG_W'(lwr_pkg::W_MIN_MAG)) begin
      w_nxt = lwr_pkg::W_MIN;
    end else begin
      w_nxt = -$signed(fin_res[lwr_pkg::XW-1:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_w_r <= w_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_w_out = out_w_r;

  // Checks
  a_w_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_w_r[lwr_pkg::XW-1] || out_w_r == '0))
    else $error("result above zero");

  a_w_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_w_r >= lwr_pkg::W_MIN))
    else $error("result below floor");

  a_x_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    x_vld_r |-> (xm_r <= lwr_pkg::X_MIN_MAG))
    else $error("sample magnitude beyond clamp");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && fin_vld) |=> ($stable(fin_res) && fin_vld))
    else $error("last stage changed during stall");

endmodule

FILE: sv/lwr_horner_step.sv
// One Horner step for the numerator and denominator lanes: v' = c + round(v * x).
// Three register stages: split multiply, round, coefficient add. Depends on lwr_pkg.
module lwr_horner_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [lwr_pkg::XMAG_W-1:0]  xm_i,
  input  lwr_pkg::fx_t                v_i    [2],
  input  lwr_pkg::fx_t                coef_i [2],
  output logic                        vld_o,
  output logic [lwr_pkg::XMAG_W-1:0]  xm_o,
  output lwr_pkg::fx_t                v_o    [2]
);

  logic                        vld1_r, vld2_r, vld3_r;
  logic [lwr_pkg::XMAG_W-1:0]  xm1_r, xm2_r, xm3_r;
  lwr_pkg::fx_t                mag [2];
  logic [lwr_pkg::PL_W-1:0]    pl_nxt [2], pl_r [2];
  logic [lwr_pkg::PH_W-1:0]    ph_nxt [2], ph_r [2];
  logic                        neg1_nxt [2], neg1_r [2], neg2_r [2];
  logic [lwr_pkg::SUM_W-1:0]   sum [2];
  logic [lwr_pkg::HMAG_W-1:0]  mag2_nxt [2], mag2_r [2];
  lwr_pkg::fx_t                ext [2];
  lwr_pkg::fx_t                v_nxt [2], v_r [2];

  // Magnitude and split partial products; x is never positive
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l]      = v_i[l][lwr_pkg::FW-1] ? -v_i[l] : v_i[l];
      pl_nxt[l]   = lwr_pkg::PL_W'(mag[l][lwr_pkg::LO_W-1:0]) * lwr_pkg::PL_W'(xm_i);
      ph_nxt[l]   = lwr_pkg::PH_W'(mag[l][lwr_pkg::MAG_W-1:lwr_pkg::LO_W])
                    * lwr_pkg::PH_W'(xm_i);
      neg1_nxt[l] = !v_i[l][lwr_pkg::FW-1];
    end
  end

  // Combine halves, round half away from zero
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = lwr_pkg::SUM_W'({ph_r[l], {lwr_pkg::LO_W{1'b0}}})
             + lwr_pkg::SUM_W'(pl_r[l])
             + (lwr_pkg::SUM_W'(1) << (lwr_pkg::FRAC_BITS - 1));
      mag2_nxt[l] = sum[l][lwr_pkg::SUM_W-1:lwr_pkg::FRAC_BITS];
    end
  end

  // Apply sign and add coefficient
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ext[l]   = lwr_pkg::fx_t'({{(lwr_pkg::FW - lwr_pkg::HMAG_W){1'b0}}, mag2_r[l]});
      v_nxt[l] = coef_i[l] + (neg2_r[l] ? -ext[l] : ext[l]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      xm1_r <= xm_i;
      xm2_r <= xm1_r;
      xm3_r <= xm2_r;
      for (int l = 0; l < 2; l++) begin
        pl_r[l]   <= pl_nxt[l];
        ph_r[l]   <= ph_nxt[l];
        neg1_r[l] <= neg1_nxt[l];
        mag2_r[l] <= mag2_nxt[l];
        neg2_r[l] <= neg1_r[l];
        v_r[l]    <= v_nxt[l];
      end
    end
  end

  assign vld_o = vld3_r;
  assign xm_o  = xm3_r;
  assign v_o   = v_r;

endmodule

FILE: sv/lwr_div_stage.sv
// One stage of the restoring divider: develops one quotient bit of |P| * 2^58 / Q.
// Depends on lwr_pkg for widths and the control struct.
module lwr_div_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [lwr_pkg::MAG_W-1:0]   rem_i,
  input  logic [lwr_pkg::MAG_W-1:0]   quo_i,
  input  logic [lwr_pkg::LOWB_W-1:0]  low_i,
  input  logic [lwr_pkg::MAG_W-1:0]   d_i,
  input  lwr_pkg::div_ctl_t           ctl_i,
  output logic                        vld_o,
  output logic [lwr_pkg::MAG_W-1:0]   rem_o,
  output logic [lwr_pkg::MAG_W-1:0]   quo_o,
  output logic [lwr_pkg::LOWB_W-1:0]  low_o,
  output logic [lwr_pkg::MAG_W-1:0]   d_o,
  output lwr_pkg::div_ctl_t           ctl_o
);

  logic                        vld_r;
  logic [lwr_pkg::MAG_W:0]     shft;
  logic [lwr_pkg::MAG_W:0]     diff;
  logic                        ge;
  logic [lwr_pkg::MAG_W-1:0]   rem_nxt, rem_r, quo_r, d_r;
  logic [lwr_pkg::LOWB_W-1:0]  low_r;
  lwr_pkg::div_ctl_t           ctl_r;

  // Shift in the next dividend bit, trial subtract
  always_comb begin
    shft    = {rem_i, low_i[lwr_pkg::LOWB_W-1]};
    diff    = shft - {1'b0, d_i};
    ge      = shft >= {1'b0, d_i};
    rem_nxt = ge ? diff[lwr_pkg::MAG_W-1:0] : shft[lwr_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_i[lwr_pkg::MAG_W-2:0], ge};
      low_r <= {low_i[lwr_pkg::LOWB_W-2:0], 1'b0};
      d_r   <= d_i;
      ctl_r <= ctl_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign low_o = low_r;
  assign d_o   = d_r;
  assign ctl_o = ctl_r;

endmodule

FILE: sv/lwr_final.sv
// Final scaling: rounds the quotient, adds A0 and multiplies by x, rounding to Q30.
// Four register stages; depends on lwr_pkg.
module lwr_final (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [lwr_pkg::MAG_W-1:0]   quo_i,
  input  lwr_pkg::div_ctl_t           ctl_i,
  output logic                        vld_o,
  output logic [lwr_pkg::FMAG_W-1:0]  res_o,
  output logic                        neg_o
);

  logic                        vld1_r, vld2_r, vld3_r, vld4_r;
  logic [lwr_pkg::MAG_W:0]     qinc;
  logic [lwr_pkg::MAG_W-1:0]   qm_nxt, qm_r;
  logic                        pneg1_r;
  logic [lwr_pkg::XMAG_W-1:0]  xm1_r, xm2_r, xm3_r;
  lwr_pkg::fx_t                qs, m_nxt, m_r, mmag;
  logic [lwr_pkg::PL_W-1:0]    pl_nxt, pl_r;
  logic [lwr_pkg::PH_W-1:0]    ph_nxt, ph_r;
  logic                        neg3_r, neg4_r;
  logic [lwr_pkg::SUM_W-1:0]   sum;
  logic [lwr_pkg::FMAG_W-1:0]  res_nxt, res_r;

  // Round quotient to Q57, override out-of-range cases
  always_comb begin
    qinc = {1'b0, quo_i} + (lwr_pkg::MAG_W + 1)'(1);
    if (ctl_i.big) begin
      qm_nxt = '0;
    end else if (ctl_i.sat) begin
      qm_nxt = lwr_pkg::MAG_W'(1) << 62;
    end else begin
      qm_nxt = qinc[lwr_pkg::MAG_W:1];
    end
  end

  // m = A0 + signed quotient
  always_comb begin
    qs    = lwr_pkg::fx_t'({1'b0, qm_r});
    m_nxt = lwr_pkg::COEF_A0 + (pneg1_r ? -qs : qs);
  end

  // Split multiply by |x|
  always_comb begin
    mmag   = m_r[lwr_pkg::FW-1] ? -m_r : m_r;
    pl_nxt = lwr_pkg::PL_W'(mmag[lwr_pkg::LO_W-1:0]) * lwr_pkg::PL_W'(xm2_r);
    ph_nxt = lwr_pkg::PH_W'(mmag[lwr_pkg::MAG_W-1:lwr_pkg::LO_W]) * lwr_pkg::PH_W'(xm2_r);
  end

  // Combine and round half away from zero to Q30
  always_comb begin
    sum = lwr_pkg::SUM_W'({ph_r, {lwr_pkg::LO_W{1'b0}}}) + lwr_pkg::SUM_W'(pl_r)
        + (lwr_pkg::SUM_W'(1) << (lwr_pkg::IFB - 1));
    res_nxt = sum[lwr_pkg::SUM_W-1:lwr_pkg::IFB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qm_r    <= qm_nxt;
      pneg1_r <= ctl_i.pneg;
      xm1_r   <= ctl_i.xm;
      m_r     <= m_nxt;
      xm2_r   <= xm1_r;
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      neg3_r  <= !m_r[lwr_pkg::FW-1];
      xm3_r   <= xm2_r;
      res_r   <= res_nxt;
      neg4_r  <= neg3_r && (xm3_r != '0);
    end
  end

  assign vld_o = vld4_r;
  assign res_o = res_r;
  assign neg_o = neg4_r;

endmodule

FILE: tb/sv/lambert_w_rational_approx_checker.sv
// Checker for the Lambert W rational approximation: watches both channels,
// predicts each result in fixed point and compares. Depends on lwr_pkg.
`timescale 1ns / 100ps

module lambert_w_rational_approx_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [27:0]  in_x_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [27:0]  out_w_out,
  output int                  fail_count,
  output int                  pending_w
);

  localparam logic [63:0] SAT_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  logic signed [27:0] w_expected_q[$];

  // round(a*b / 2^sh), ties away from zero, saturated to int64 magnitude
  function automatic longint round_mul(longint a, longint b, int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    logic [127:0] res;
    logic         neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod + (128'd1 << (sh - 1));
    res  = prod >> sh;
    if (res > {64'd0, SAT_MAG}) res = {64'd0, SAT_MAG};
    return neg ? -longint'(res[63:0]) : longint'(res[63:0]);
  endfunction

  // round(n * 2^IFB / d), magnitude, saturated at 2^62
  function automatic logic [63:0] quot_q57(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] t;
    if (d == 0) return 64'd1 << 62;
    if (d > (64'd1 << 62)) return 64'd0;
    q = n / d;
    r = n % d;
    if (q >= 32) return 64'd1 << 62;
    t = 0;
    for (int i = 0; i < lwr_pkg::IFB + 1; i++) begin
      r = r << 1;
      t = t << 1;
      if (r >= d) begin
        r    = r - d;
        t[0] = 1'b1;
      end
    end
    return (q << lwr_pkg::IFB) + ((t + 64'd1) >> 1);
  endfunction

  function automatic logic signed [27:0] lambert_w(logic signed [27:0] x_in);
    longint      x;
    longint      x57;
    longint      p;
    longint      q;
    longint      quot;
    longint      w;
    logic [63:0] qm;
    x = x_in;
    if (x > 0) x = 0;
    if (x < -longint'(lwr_pkg::X_MIN_RAW)) x = -longint'(lwr_pkg::X_MIN_RAW);
    x57 = x <<< (lwr_pkg::IFB - lwr_pkg::FRAC_BITS);
    p = lwr_pkg::COEF_P[5];
    for (int k = 4; k >= 0; k--) p = lwr_pkg::COEF_P[k] + round_mul(p, x57, lwr_pkg::IFB);
    q = lwr_pkg::COEF_Q[5];
    for (int k = 4; k >= 0; k--) q = lwr_pkg::COEF_Q[k] + round_mul(q, x57, lwr_pkg::IFB);
    qm   = quot_q57((p < 0) ? -p : p, (q > 0) ? q : 0);
    quot = (p < 0) ? -longint'(qm) : longint'(qm);
    w    = round_mul(x57, lwr_pkg::COEF_A0 + quot, 2 * lwr_pkg::IFB - lwr_pkg::FRAC_BITS);
    if (w > 0) w = 0;
    if (w < -longint'(121000000)) w = -longint'(121000000);
    return w[27:0];
  endfunction

  // Print one line and count
  task automatic report_mismatch(string what, logic signed [27:0] got,
                                 logic signed [27:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_w = w_expected_q.size();

  // Predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) w_expected_q.push_back(lambert_w(in_x_in));
      if (out_valid && out_ready) begin
        if (w_expected_q.size() == 0) report_mismatch("unexpected w_out", out_w_out, 0);
        else begin
          if (out_w_out !== w_expected_q[0])
            report_mismatch("w_out", out_w_out, w_expected_q[0]);
          void'(w_expected_q.pop_front());
        end
      end
    end
  end

endmodule

FILE: tb/sv/lambert_w_rational_approx_test.sv
// Testbench top for the Lambert W rational approximation: clock, reset,
// stimulus and verdict. Depends on lwr_pkg and the checker module.
`timescale 1ns / 100ps

module lambert_w_rational_approx_test;

  localparam int LATENCY    = 85;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_N   = 1100;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [27:0] in_x_in = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [27:0] out_w_out;
  int                 fail_count;
  int                 pending_w;
  bit                 no_idle = 0;
  bit                 hold_off = 0;
  int                 quiet_cycles = 0;

  always #2 clk = ~clk;

  lambert_w_rational_approx dut (.*);

  lambert_w_rational_approx_checker checker_i (.*);

  // Watchdog: end the run after a long stretch with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off when asked
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // Drive one sample and hold until accepted
  task automatic send_x(logic signed [27:0] x);
    in_valid <= 1;
    in_x_in  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  function automatic logic signed [27:0] rand_x();
    case ($urandom_range(0, 9))
      0: return 28'($urandom);                                  // any pattern, clamps
      1: return lwr_pkg::X_LOW + 28'($urandom_range(0, 15));    // near the low bound
      2: return -28'($urandom_range(0, 15));                    // near zero
      default: return -28'($urandom_range(0, lwr_pkg::X_MIN_RAW));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: range ends, clamps on both sides, field extremes
    send_x(28'sd0);
    send_x(-28'sd1);
    send_x(lwr_pkg::X_LOW);
    send_x(lwr_pkg::X_LOW + 28'sd1);
    send_x(lwr_pkg::X_LOW - 28'sd1);
    send_x(28'sd1);
    send_x(28'h7FFFFFF);
    send_x(28'h8000000);
    send_x(28'hAAAAAAA);
    send_x(28'h5555555);
    send_x(-28'sd53687091);

    // Pause until the pipeline drains
    in_valid <= 0;
    while (pending_w != 0) @(negedge clk);

    // Long receiver hold-off while samples keep coming
    hold_off = 1;
    for (int i = 0; i < 200; i++) send_x(rand_x());

    for (int i = 0; i < RANDOM_N; i++) begin
      if (i == RANDOM_N - 200) no_idle = 1;
      send_x(rand_x());
    end
    in_valid <= 0;

    while (pending_w != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
